### src/hkrb_pkg.sv
package hkrb_pkg;

    typedef enum logic [2:0] {
        PH_STOP  = 3'd0,
        PH_BRAKE = 3'd1,
        PH_START = 3'd2,
        PH_KICK  = 3'd3,
        PH_RUN   = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        CFG_MOTOR_GAIN   = 3'd0,
        CFG_PERIOD_COUNT = 3'd1,
        CFG_BRAKE_GAIN   = 3'd2,
        CFG_BRAKE_MS     = 3'd3,
        CFG_KICK_MS      = 3'd4,
        CFG_SETTLE_MS    = 3'd5,
        CFG_MIN_ON_MS    = 3'd6,
        CFG_MAX_ON_MS    = 3'd7
    } t_cfg_idx;

    localparam logic [6:0]  GAIN_MAX         = 7'd100;
    localparam logic [8:0]  PERIOD_RESET     = 9'd128;
    localparam logic [14:0] MAX_ON_RESET     = 15'd30000;
    localparam logic [15:0] SINCE_MAX        = 16'hffff;

    typedef struct packed {
        logic [6:0]  motor_gain;
        logic [8:0]  period_count;
        logic [6:0]  brake_gain;
        logic [14:0] brake_ms;
        logic [14:0] kick_ms;
        logic [14:0] settle_ms;
        logic [14:0] min_on_ms;
        logic [14:0] max_on_ms;
    } t_cfg;

    typedef struct packed {
        logic [6:0] kick;
        logic [6:0] run;
        logic [6:0] brake;
    } t_duty_set;

    typedef struct packed {
        logic        motor_enable;
        logic        clock_enable;
        logic [6:0]  duty_level;
        logic [7:0]  n_reg;
        logic [7:0]  d_reg;
        t_phase      phase;
        logic [14:0] remaining_ms;
    } t_result;

endpackage

### src/hkrb_ifs.sv
interface hkrb_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] duration_ms;

    modport source (output valid, cmd, duration_ms, input ready);
    modport sink (input valid, cmd, duration_ms, output ready);
endinterface

interface hkrb_out_if;
    logic        valid;
    logic        ready;
    logic        motor_enable;
    logic        clock_enable;
    logic [6:0]  duty_level;
    logic [7:0]  n_reg;
    logic [7:0]  d_reg;
    logic [2:0]  phase;
    logic [14:0] remaining_ms;

    modport source (output valid, motor_enable, clock_enable, duty_level, n_reg, d_reg,
                    phase, remaining_ms, input ready);
    modport sink (input valid, motor_enable, clock_enable, duty_level, n_reg, d_reg,
                  phase, remaining_ms, output ready);
endinterface

### src/hkrb_duty_map.sv
module hkrb_duty_map import hkrb_pkg::*; #(
    parameter int DUTY_HALF = 64
) (
    input  logic [6:0] i_motor_gain,
    input  logic [6:0] i_brake_gain,
    output t_duty_set  o_duty
);

    typedef logic [6:0] t_lvl_tab [128];

    function automatic t_lvl_tab f_build_tab();
        t_lvl_tab tab;
        int       lv;
        for (int i = 0; i < 128; i++) begin
            lv = (2 * i * (DUTY_HALF - 2) + 100) / 200;
            if (lv == 0 && i != 0) begin
                lv = 1;
            end
            tab[i] = 7'(lv);
        end
        return tab;
    endfunction

    localparam t_lvl_tab   LVL_TAB = f_build_tab();
    localparam logic [8:0] HALF    = 9'(DUTY_HALF);

    logic [6:0] run_mag;
    logic [6:0] brake_mag;
    logic [8:0] kick_d;
    logic [8:0] run_d;
    logic [8:0] brake_d;

    assign run_mag   = (i_motor_gain > GAIN_MAX) ? GAIN_MAX : i_motor_gain;
    assign brake_mag = (i_brake_gain > GAIN_MAX) ? GAIN_MAX : i_brake_gain;

    always_comb begin
        kick_d  = HALF + {2'b00, LVL_TAB[GAIN_MAX]};
        run_d   = (run_mag == '0) ? '0 : HALF + {2'b00, LVL_TAB[run_mag]};
        brake_d = (brake_mag == '0) ? '0 : HALF - {2'b00, LVL_TAB[brake_mag]};
    end

    assign o_duty.kick  = kick_d[6:0];
    assign o_duty.run   = run_d[6:0];
    assign o_duty.brake = brake_d[6:0];

endmodule

### src/haptic_kick_run_brake_sequencer.sv
// Haptic motor sequencer: stop, kick, run and brake phases for a vibration motor
// driven by a dual-edge PWM clock generator.
// Input channel i_in: one beat is a one-millisecond tick (cmd 0) or a vibration
// request (cmd 1) with duration_ms; a zero duration asks for a stop.
// Output channel o_out: one beat per input beat, carrying the motor and clock
// enables, the duty level, the N and D register bytes, the phase and the
// remaining time.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx.
// The result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the receiver is ready; the whole step of
// the phase sequencer is a single pass of logic between the state registers and
// the result register. A new input beat is taken while a finished result waits,
// as long as the result register is emptied in that same cycle; a stalled receiver
// holds the result and blocks only further input beats.
// Reset (synchronous, active low) stops the motor, clears all timers and pending
// actions and loads the configuration defaults.
module haptic_kick_run_brake_sequencer import hkrb_pkg::*; #(
    parameter int DUTY_HALF  = 64,
    parameter int TIMER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_data,
    hkrb_in_if.sink     i_in,
    hkrb_out_if.source  o_out
);

    localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

    typedef struct packed {
        t_phase                phase;
        logic [TIMER_BITS-1:0] timer;
        logic                  running;
        logic [14:0]           on_dur;
        logic [15:0]           since;
        logic                  on_pend;
        logic [TIMER_BITS-1:0] on_dly;
        logic                  off_pend;
        logic [14:0]           off_dly;
        logic                  pin;
        logic                  cbcr;
        logic [7:0]            n_hold;
        logic [6:0]            duty;
    } t_core;

    t_cfg       r_cfg;
    t_core      r_core;
    t_core      n_core;
    t_result    r_res;
    t_result    n_res;
    logic       r_valid;
    t_duty_set  duty_set;
    logic [8:0] period_m1;
    logic [7:0] n_byte;
    logic       run_stop;
    logic       accept;

    hkrb_duty_map #(
        .DUTY_HALF(DUTY_HALF)
    ) u_duty_map (
        .i_motor_gain(r_cfg.motor_gain),
        .i_brake_gain(r_cfg.brake_gain),
        .o_duty      (duty_set)
    );

    function automatic logic [TIMER_BITS-1:0] f_load(input logic [15:0] ms);
        logic [31:0] w;
        w = {16'b0, ms};
        if (w == '0) begin
            w = 32'd1;
        end
        if (w > TIMER_MAX) begin
            w = TIMER_MAX;
        end
        return w[TIMER_BITS-1:0];
    endfunction

    function automatic t_core f_drive(input t_core s, input logic stop, input t_cfg c,
                                      input t_duty_set d, input logic [7:0] nb);
        t_core  r;
        t_phase nx;
        r = s;
        if (stop) begin
            if (s.phase != PH_STOP && s.phase != PH_BRAKE && c.brake_ms != '0) begin
                r.n_hold  = nb;
                r.duty    = d.brake;
                r.cbcr    = 1'b1;
                r.phase   = PH_BRAKE;
                r.timer   = f_load({1'b0, c.brake_ms});
                r.running = 1'b1;
            end else begin
                r.pin   = 1'b0;
                r.cbcr  = 1'b0;
                r.phase = PH_STOP;
            end
        end else begin
            unique case (s.phase)
                PH_STOP, PH_BRAKE: nx = (c.kick_ms != '0) ? PH_KICK : PH_START;
                PH_KICK, PH_START: nx = PH_RUN;
                default:           nx = s.phase;
            endcase
            r.off_pend = 1'b0;
            r.off_dly  = '0;
            if (!(s.phase == PH_KICK && s.running)) begin
                r.n_hold  = nb;
                r.cbcr    = 1'b1;
                r.pin     = 1'b1;
                r.phase   = nx;
                r.running = 1'b1;
                if (nx == PH_KICK) begin
                    r.duty  = d.kick;
                    r.timer = f_load({1'b0, c.kick_ms});
                end else begin
                    r.duty  = d.run;
                    r.timer = f_load({1'b0, s.on_dur} + {1'b0, c.settle_ms});
                end
            end
        end
        return r;
    endfunction

    assign period_m1 = r_cfg.period_count - 9'd1;
    assign n_byte    = ~period_m1[7:0];
    assign run_stop  = (r_cfg.motor_gain == '0);
    assign accept    = i_in.valid && i_in.ready;

    assign i_in.ready = !r_valid || o_out.ready;

    always_comb begin
        t_core                 s;
        logic [14:0]           req;
        logic [TIMER_BITS-1:0] dly;
        logic                  stop_ok;
        s       = r_core;
        req     = '0;
        dly     = '0;
        stop_ok = 1'b0;
        if (!i_in.cmd) begin
            if (s.since != SINCE_MAX) begin
                s.since = s.since + 16'd1;
            end
            if (s.running) begin
                if (s.timer != '0) begin
                    s.timer = s.timer - TIMER_BITS'(1);
                end
                if (s.timer == '0) begin
                    s.running = 1'b0;
                    if (s.phase == PH_KICK) begin
                        if (!s.on_pend) begin
                            s = f_drive(s, run_stop, r_cfg, duty_set, n_byte);
                        end
                    end else if (!s.off_pend) begin
                        s = f_drive(s, 1'b1, r_cfg, duty_set, n_byte);
                    end
                end
            end
            if (s.on_pend) begin
                if (s.on_dly != '0) begin
                    s.on_dly = s.on_dly - TIMER_BITS'(1);
                end
                if (s.on_dly == '0) begin
                    s.on_pend = 1'b0;
                    s = f_drive(s, run_stop, r_cfg, duty_set, n_byte);
                end
            end
            if (s.off_pend) begin
                if (s.off_dly != '0) begin
                    s.off_dly = s.off_dly - 15'd1;
                end
                if (s.off_dly == '0) begin
                    s.off_pend = 1'b0;
                    s = f_drive(s, 1'b1, r_cfg, duty_set, n_byte);
                end
            end
        end else if (i_in.duration_ms != '0) begin
            if (i_in.duration_ms > {1'b0, r_cfg.max_on_ms}) begin
                req = r_cfg.max_on_ms;
            end else begin
                req = i_in.duration_ms[14:0];
            end
            s.since  = '0;
            s.on_dur = req;
            if (s.phase == PH_BRAKE && s.running) begin
                dly = s.timer;
            end
            if (!s.on_pend) begin
                if (dly == '0) begin
                    s = f_drive(s, run_stop, r_cfg, duty_set, n_byte);
                end else begin
                    s.on_pend = 1'b1;
                    s.on_dly  = dly;
                end
            end
        end else begin
            stop_ok = !(r_cfg.min_on_ms != '0 && s.on_dur < r_cfg.min_on_ms);
            if (stop_ok && ({1'b0, s.since} + 17'd1 < {2'b00, s.on_dur})
                    && !s.off_pend) begin
                if (r_cfg.settle_ms == '0) begin
                    s = f_drive(s, 1'b1, r_cfg, duty_set, n_byte);
                end else begin
                    s.off_pend = 1'b1;
                    s.off_dly  = r_cfg.settle_ms;
                end
            end
        end
        n_core = s;
    end

    always_comb begin
        n_res.motor_enable = n_core.pin;
        n_res.clock_enable = n_core.cbcr;
        n_res.duty_level   = n_core.duty;
        n_res.n_reg        = n_core.n_hold;
        n_res.d_reg        = ~{n_core.duty, 1'b0};
        n_res.phase        = n_core.phase;
        if (!n_core.running) begin
            n_res.remaining_ms = '0;
        end else if (n_core.timer < TIMER_BITS'(n_core.on_dur)) begin
            n_res.remaining_ms = n_core.timer[14:0];
        end else begin
            n_res.remaining_ms = n_core.on_dur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.motor_gain   <= '0;
            r_cfg.period_count <= PERIOD_RESET;
            r_cfg.brake_gain   <= '0;
            r_cfg.brake_ms     <= '0;
            r_cfg.kick_ms      <= '0;
            r_cfg.settle_ms    <= '0;
            r_cfg.min_on_ms    <= '0;
            r_cfg.max_on_ms    <= MAX_ON_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MOTOR_GAIN:   r_cfg.motor_gain   <= i_cfg_data[6:0];
                CFG_PERIOD_COUNT: r_cfg.period_count <= i_cfg_data[8:0];
                CFG_BRAKE_GAIN:   r_cfg.brake_gain   <= i_cfg_data[6:0];
                CFG_BRAKE_MS:     r_cfg.brake_ms     <= i_cfg_data;
                CFG_KICK_MS:      r_cfg.kick_ms      <= i_cfg_data;
                CFG_SETTLE_MS:    r_cfg.settle_ms    <= i_cfg_data;
                CFG_MIN_ON_MS:    r_cfg.min_on_ms    <= i_cfg_data;
                CFG_MAX_ON_MS:    r_cfg.max_on_ms    <= i_cfg_data;
                default:          r_cfg.max_on_ms    <= r_cfg.max_on_ms;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_core  <= n_core;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.motor_enable = r_res.motor_enable;
    assign o_out.clock_enable = r_res.clock_enable;
    assign o_out.duty_level   = r_res.duty_level;
    assign o_out.n_reg        = r_res.n_reg;
    assign o_out.d_reg        = r_res.d_reg;
    assign o_out.phase        = r_res.phase;
    assign o_out.remaining_ms = r_res.remaining_ms;

endmodule

### sim/haptic_seq_checker.sv
`timescale 1ns / 100ps

module haptic_seq_checker import hkrb_pkg::*; #(
    parameter int DUTY_HALF  = 64,
    parameter int TIMER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_data,
    hkrb_in_if          i_in_mon,
    hkrb_out_if         i_out_mon,
    output int          o_pending,
    output int          o_fail_count
);

    localparam int unsigned TIMER_MAX = (32'd1 << TIMER_BITS) - 1;

    t_cfg                  cfg;
    t_phase                ph;
    bit [TIMER_BITS-1:0]   ph_timer;
    bit                    tmr_run;
    bit [14:0]             on_dur;
    bit [15:0]             since;
    bit                    on_pend;
    bit [TIMER_BITS-1:0]   on_dly;
    bit                    off_pend;
    bit [15:0]             off_dly;
    bit                    clk_on;
    bit [6:0]              duty;
    bit                    pin;
    bit                    cbcr;
    bit [7:0]              n_byte;

    t_result result_q[$];
    int      pending_cnt = 0;
    int      fail_total  = 0;

    assign o_pending    = pending_cnt;
    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_total++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
    endtask

    function automatic void clear_state();
        cfg.motor_gain   = '0;
        cfg.period_count = PERIOD_RESET;
        cfg.brake_gain   = '0;
        cfg.brake_ms     = '0;
        cfg.kick_ms      = '0;
        cfg.settle_ms    = '0;
        cfg.min_on_ms    = '0;
        cfg.max_on_ms    = MAX_ON_RESET;
        ph       = PH_STOP;
        ph_timer = '0;
        tmr_run  = 1'b0;
        on_dur   = '0;
        since    = '0;
        on_pend  = 1'b0;
        on_dly   = '0;
        off_pend = 1'b0;
        off_dly  = '0;
        clk_on   = 1'b0;
        duty     = '0;
        pin      = 1'b0;
        cbcr     = 1'b0;
        n_byte   = '0;
    endfunction

    function automatic void write_cfg(input logic [2:0] idx, input logic [14:0] data);
        case (t_cfg_idx'(idx))
            CFG_MOTOR_GAIN:   cfg.motor_gain   = data[6:0];
            CFG_PERIOD_COUNT: cfg.period_count = data[8:0];
            CFG_BRAKE_GAIN:   cfg.brake_gain   = data[6:0];
            CFG_BRAKE_MS:     cfg.brake_ms     = data;
            CFG_KICK_MS:      cfg.kick_ms      = data;
            CFG_SETTLE_MS:    cfg.settle_ms    = data;
            CFG_MIN_ON_MS:    cfg.min_on_ms    = data;
            default:          cfg.max_on_ms    = data;
        endcase
    endfunction

    function automatic int unsigned sat_gain(input int unsigned g);
        return (g > GAIN_MAX) ? GAIN_MAX : g;
    endfunction

    function automatic int duty_step(input int amp);
        int unsigned mag;
        int unsigned lvl;
        mag = (amp < 0) ? -amp : amp;
        lvl = (2 * mag * (DUTY_HALF - 2) + 100) / 200;
        if (lvl == 0 && mag != 0)
            lvl = 1;
        return (amp < 0) ? -int'(lvl) : int'(lvl);
    endfunction

    function automatic void load_pwm(input bit en, input int amp);
        int d;
        d = 0;
        if (en) begin
            if (amp != 0)
                d = DUTY_HALF + duty_step(amp);
            n_byte = 8'(~(int'(cfg.period_count) - 1));
            duty   = 7'(d);
        end
        cbcr = en;
    endfunction

    function automatic void arm_timer(input int unsigned ms);
        if (ms == 0)
            ms = 1;
        if (ms > TIMER_MAX)
            ms = TIMER_MAX;
        ph_timer = TIMER_BITS'(ms);
        tmr_run  = 1'b1;
    endfunction

    function automatic void drive_motor(input int unsigned gain);
        t_phase      nxt;
        int unsigned dur;
        gain = sat_gain(gain);
        if (gain == 0) begin
            if (ph > PH_BRAKE && cfg.brake_ms != 0) begin
                load_pwm(1'b1, -int'(sat_gain(cfg.brake_gain)));
                ph = PH_BRAKE;
                arm_timer(cfg.brake_ms);
                return;
            end
            pin = 1'b0;
            load_pwm(1'b0, 0);
            ph     = PH_STOP;
            clk_on = 1'b0;
            return;
        end
        if (ph == PH_STOP || ph == PH_BRAKE) begin
            if (cfg.kick_ms != 0)
                nxt = PH_KICK;
            else
                nxt = PH_START;
        end else if (ph == PH_KICK || ph == PH_START) begin
            nxt = PH_RUN;
        end else begin
            nxt = ph;
        end
        clk_on   = 1'b1;
        off_pend = 1'b0;
        off_dly  = '0;
        // an active kick keeps its own timer
        if (ph == PH_KICK && tmr_run)
            return;
        tmr_run  = 1'b0;
        ph_timer = '0;
        if (nxt == PH_KICK) begin
            load_pwm(1'b1, 100);
            dur = cfg.kick_ms;
        end else begin
            load_pwm(1'b1, int'(gain));
            dur = on_dur + cfg.settle_ms;
        end
        pin = 1'b1;
        ph  = nxt;
        arm_timer(dur);
    endfunction

    function automatic void schedule_start(input int unsigned dly);
        if (on_pend)
            return;
        if (dly == 0) begin
            drive_motor(cfg.motor_gain);
        end else begin
            on_pend = 1'b1;
            on_dly  = TIMER_BITS'(dly);
        end
    endfunction

    function automatic void schedule_stop(input int unsigned dly);
        if (off_pend)
            return;
        if (dly == 0) begin
            drive_motor(0);
        end else begin
            off_pend = 1'b1;
            off_dly  = 16'(dly);
        end
    endfunction

    function automatic void tick_step();
        if (since != SINCE_MAX)
            since++;
        if (tmr_run) begin
            if (ph_timer > 0)
                ph_timer--;
            if (ph_timer == 0) begin
                tmr_run = 1'b0;
                if (ph == PH_KICK)
                    schedule_start(0);
                else
                    schedule_stop(0);
            end
        end
        if (on_pend) begin
            if (on_dly > 0)
                on_dly--;
            if (on_dly == 0) begin
                on_pend = 1'b0;
                drive_motor(cfg.motor_gain);
            end
        end
        if (off_pend) begin
            if (off_dly > 0)
                off_dly--;
            if (off_dly == 0) begin
                off_pend = 1'b0;
                drive_motor(0);
            end
        end
    endfunction

    function automatic void request_step(input bit [15:0] req);
        int unsigned v;
        int unsigned dly;
        bit          forced;
        v = req;
        if (v > 0) begin
            dly = 0;
            if (v > cfg.max_on_ms)
                v = cfg.max_on_ms;
            since  = '0;
            on_dur = 15'(v);
            // a start during braking waits out the brake
            if (ph == PH_BRAKE && tmr_run)
                dly = ph_timer;
            schedule_start(dly);
        end else begin
            forced = !(cfg.min_on_ms != 0 && on_dur < cfg.min_on_ms);
            if (forced && int'(since) + 1 < int'(on_dur))
                schedule_stop(cfg.settle_ms);
        end
    endfunction

    function automatic t_result predict_motor(input logic is_req, input logic [15:0] req);
        t_result     r;
        int unsigned rem;
        if (is_req)
            request_step(req);
        else
            tick_step();
        rem = 0;
        if (tmr_run)
            rem = (ph_timer < on_dur) ? ph_timer : on_dur;
        r.motor_enable = pin;
        r.clock_enable = cbcr;
        r.duty_level   = duty;
        r.n_reg        = n_byte;
        r.d_reg        = ~{duty, 1'b0};
        r.phase        = ph;
        r.remaining_ms = 15'(rem);
        return r;
    endfunction

    always @(posedge i_clk) begin : beat_track
        t_result want;
        if (!i_rst_n) begin
            clear_state();
            result_q.delete();
        end else begin
            if (i_cfg_we)
                write_cfg(i_cfg_idx, i_cfg_data);
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("result beat with no expected result");
                end else begin
                    want = result_q.pop_front();
                    check_field("motor_enable", i_out_mon.motor_enable, want.motor_enable);
                    check_field("clock_enable", i_out_mon.clock_enable, want.clock_enable);
                    check_field("duty_level", i_out_mon.duty_level, want.duty_level);
                    check_field("n_reg", i_out_mon.n_reg, want.n_reg);
                    check_field("d_reg", i_out_mon.d_reg, want.d_reg);
                    check_field("phase", i_out_mon.phase, want.phase);
                    check_field("remaining_ms", i_out_mon.remaining_ms, want.remaining_ms);
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                result_q.push_back(predict_motor(i_in_mon.cmd, i_in_mon.duration_ms));
        end
        pending_cnt = result_q.size();
    end

endmodule

### sim/haptic_kick_run_brake_sequencer_tb.sv
`timescale 1ns / 100ps

module haptic_kick_run_brake_sequencer_tb;
    import hkrb_pkg::*;

    localparam int   DUTY_HALF       = 64;
    localparam int   TIMER_BITS      = 16;
    localparam int   IDLE_LIMIT      = 2000;
    localparam int   RANDOM_PHASES   = 8;
    localparam int   ITEMS_PER_PHASE = 250;
    localparam logic CMD_TICK        = 1'b0;
    localparam logic CMD_REQUEST     = 1'b1;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [14:0] cfg_data;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          calm;

    hkrb_in_if  in_if ();
    hkrb_out_if out_if ();

    haptic_kick_run_brake_sequencer #(
        .DUTY_HALF  (DUTY_HALF),
        .TIMER_BITS (TIMER_BITS)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    haptic_seq_checker #(
        .DUTY_HALF  (DUTY_HALF),
        .TIMER_BITS (TIMER_BITS)
    ) i_seq_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_mon     (in_if),
        .i_out_mon    (out_if),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial begin : rx_stall
        int stall;
        out_if.ready = 1'b0;
        @(negedge clk);
        forever begin
            out_if.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge clk);
            stall = pick_gap();
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("haptic_kick_run_brake_sequencer regression: fail");
            $finish;
        end
    end

    task automatic send_beat(input logic c, input logic [15:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.cmd         <= c;
        in_if.duration_ms <= d;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // hold input and wait for every outstanding result
    task automatic drain();
        in_if.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= 15'(val);
        @(negedge clk);
    endtask

    task automatic apply_settings(input t_cfg s);
        drain();
        write_reg(CFG_MOTOR_GAIN, s.motor_gain);
        write_reg(CFG_PERIOD_COUNT, s.period_count);
        write_reg(CFG_BRAKE_GAIN, s.brake_gain);
        write_reg(CFG_BRAKE_MS, s.brake_ms);
        write_reg(CFG_KICK_MS, s.kick_ms);
        write_reg(CFG_SETTLE_MS, s.settle_ms);
        write_reg(CFG_MIN_ON_MS, s.min_on_ms);
        write_reg(CFG_MAX_ON_MS, s.max_on_ms);
        cfg_we <= 1'b0;
    endtask

    function automatic t_cfg pick_settings(input int k);
        t_cfg s;
        if (k == 0) begin
            s = '{motor_gain: 0, period_count: 1, brake_gain: 0, brake_ms: 0,
                  kick_ms: 0, settle_ms: 0, min_on_ms: 0, max_on_ms: 1};
        end else if (k == 1) begin
            s = '{motor_gain: 127, period_count: 256, brake_gain: 127, brake_ms: 30000,
                  kick_ms: 30000, settle_ms: 30000, min_on_ms: 30000, max_on_ms: 30000};
        end else begin
            s.motor_gain   = 7'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 127));
            s.period_count = 9'($urandom_range(1, 256));
            s.brake_gain   = 7'($urandom_range(0, 127));
            s.brake_ms     = 15'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
            s.kick_ms      = 15'(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
            s.settle_ms    = 15'($urandom_range(0, 6));
            s.min_on_ms    = 15'(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 40));
            s.max_on_ms    = 15'(($urandom_range(0, 4) == 0) ? 30000 : $urandom_range(1, 60));
        end
        return s;
    endfunction

    // request followed by a run of ticks with the odd stop request
    task automatic run_vibration(input int budget, input bit mid_drain);
        int          n;
        int          len;
        logic [15:0] dur;
        n = 0;
        while (n < budget) begin
            if ($urandom_range(0, 9) == 0)
                dur = 16'($urandom_range(0, 65535));
            else
                dur = 16'($urandom_range(1, 40));
            send_beat(CMD_REQUEST, dur);
            n++;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : $urandom_range(5, 70);
            for (int i = 0; i < len && n < budget; i++) begin
                if ($urandom_range(0, 24) == 0)
                    send_beat(CMD_REQUEST, 16'd0);
                else
                    send_beat(CMD_TICK, 16'($urandom));
                n++;
            end
            if (mid_drain && n >= budget / 2) begin
                drain();
                mid_drain = 1'b0;
            end
        end
    endtask

    initial begin : stimulus
        t_cfg s;
        rst_n             = 1'b0;
        in_if.valid       = 1'b0;
        in_if.cmd         = CMD_TICK;
        in_if.duration_ms = '0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_MOTOR_GAIN;
        cfg_data          = '0;
        calm              = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // defaults: idle tick, stop while idle, start with zero gain
        send_beat(CMD_TICK, 16'hffff);
        send_beat(CMD_REQUEST, 16'd0);
        send_beat(CMD_REQUEST, 16'd1);

        s = '{motor_gain: 127, period_count: 256, brake_gain: 127, brake_ms: 3,
              kick_ms: 2, settle_ms: 1, min_on_ms: 0, max_on_ms: 5};
        apply_settings(s);
        send_beat(CMD_REQUEST, 16'hffff);
        send_beat(CMD_REQUEST, 16'd9);
        repeat (3) send_beat(CMD_TICK, 16'd0);
        send_beat(CMD_REQUEST, 16'd0);
        repeat (2) send_beat(CMD_TICK, 16'd0);
        send_beat(CMD_REQUEST, 16'd4);
        repeat (3) send_beat(CMD_TICK, 16'd0);
        send_beat(CMD_REQUEST, 16'd0);
        repeat (9) send_beat(CMD_TICK, 16'd0);

        for (int k = 0; k < RANDOM_PHASES; k++) begin
            apply_settings(pick_settings(k));
            calm = (k == 4) || ($urandom_range(0, 3) == 0);
            run_vibration(ITEMS_PER_PHASE, k == 3);
        end
        calm = 1'b0;

        drain();
        repeat (5) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("haptic_kick_run_brake_sequencer regression: pass");
        else
            $display("haptic_kick_run_brake_sequencer regression: fail");
        $finish;
    end

endmodule
